// File: hw/rtl/lia_pkg.sv
// Package for the largest-island-after-one-flip block.
// Holds the fixed field widths, the default grid limit and the neighbor direction codes.
// No dependencies; the loader, labeler, top level and checker import it.
package lia_pkg;

	// Fixed widths of the configuration register and the result field.
	localparam int CFG_W = 7;
	localparam int OUT_W = 13;

	// Default largest grid side.
	localparam int DEF_MAX_SIDE = 64;

	// Neighbor direction codes, visited in this order while scoring.
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

endpackage

// File: hw/rtl/lia_queue.sv
// Small first-in first-out queue of flop storage.
// Used between the loader and the labeler, and as the result queue.
// Depends on nothing but its parameters.
module lia_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == NW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: hw/rtl/lia_loader.sv
// Front part: takes the side register and incoming cells, tracks the position in the grid.
// Each cell leaves as one transaction tagged with its index, side, last flag and all-land flag.
// Depends on lia_pkg.
module lia_loader #(
	parameter int MAX_SIDE = lia_pkg::DEF_MAX_SIDE,
	parameter int ITEM_W   = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [lia_pkg::CFG_W-1:0] cfg_data,
	input  logic                    push,
	output logic                    full,
	input  logic                    cell_value,
	output logic                    q_push,
	input  logic                    q_full,
	output logic [ITEM_W-1:0]       q_data
);
	import lia_pkg::*;

	localparam int MAX_CELLS = MAX_SIDE * MAX_SIDE;
	localparam int IW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int CW = $clog2(MAX_CELLS + 1);

	typedef struct packed {
		logic          land;
		logic [IW-1:0] idx;
		logic          last;
		logic          all_land;
		logic [SW-1:0] side;
	} item_t;

	logic [CFG_W-1:0] side_q;
	logic [IW-1:0]    idx_q;
	logic [CW-1:0]    ones_q;
	logic [SW-1:0]    side_use;
	logic [CW-1:0]    total;
	logic [CW-1:0]    ones_next;
	logic             last;
	logic             accept;
	item_t            item;

	// Clamp the register into the supported side range.
	always_comb begin
		if (side_q == '0) begin
			side_use = SW'(1);
		end else if (int'(side_q) > MAX_SIDE) begin
			side_use = SW'(MAX_SIDE);
		end else begin
			side_use = SW'(side_q);
		end
	end

	assign total     = CW'(side_use * side_use);
	assign ones_next = ones_q + CW'(cell_value);
	assign last      = (CW'(idx_q) == total - 1'b1);
	assign accept    = push && !q_full;

	assign full      = q_full;
	assign cfg_ready = 1'b1;
	assign q_push    = accept;

	always_comb begin
		item.land     = cell_value;
		item.idx      = idx_q;
		item.last     = last;
		item.all_land = (ones_next == total);
		item.side     = side_use;
	end
	assign q_data = ITEM_W'(item);

	// Side register and grid position; a register write restarts the grid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= CFG_W'(MAX_SIDE);
			idx_q  <= '0;
			ones_q <= '0;
		end else if (cfg_valid) begin
			side_q <= cfg_data;
			idx_q  <= '0;
			ones_q <= '0;
		end else if (accept) begin
			if (last) begin
				idx_q  <= '0;
				ones_q <= '0;
			end else begin
				idx_q  <= idx_q + 1'b1;
				ones_q <= ones_next;
			end
		end
	end

endmodule

// File: hw/rtl/lia_labeler.sv
// Back part: stores the grid, joins land regions with union-find and scores water cells.
// Owns the cell, parent and size memories; results go to the result queue.
// Depends on lia_pkg.
module lia_labeler #(
	parameter int MAX_SIDE = lia_pkg::DEF_MAX_SIDE,
	parameter int ITEM_W   = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ITEM_W-1:0]         q_data,
	input  logic                      q_empty,
	output logic                      q_pop,
	output logic                      res_push,
	input  logic                      res_full,
	output logic [lia_pkg::OUT_W-1:0] res_data
);
	import lia_pkg::*;

	localparam int MAX_CELLS = MAX_SIDE * MAX_SIDE;
	localparam int IW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int CW = $clog2(MAX_CELLS + 1);
	localparam int RW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

	typedef struct packed {
		logic          land;
		logic [IW-1:0] idx;
		logic          last;
		logic          all_land;
		logic [SW-1:0] side;
	} item_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CELL, S_CELL_W, S_CELL_C, S_NB, S_NB_W, S_NB_C,
		S_FIND, S_FIND_W, S_FIND_C, S_SZA, S_SZA_W, S_SZB, S_SZB_W,
		S_JOIN, S_ADD, S_ADV, S_CELLEND, S_NEXT, S_DONE
	} state_t;

	// Memories.
	logic          cell_mem [MAX_CELLS];
	logic [IW-1:0] par_mem  [MAX_CELLS];
	logic [CW-1:0] sz_mem   [MAX_CELLS];

	state_t        state_q;
	logic          scoring_q;
	logic          find_sel_q;
	logic          all_land_q;
	logic [SW-1:0] n_q;
	logic [IW-1:0] i_q;
	logic [RW-1:0] r_q;
	logic [RW-1:0] c_q;
	logic [1:0]    k_q;
	logic [IW-1:0] x_q;
	logic [IW-1:0] ra_q;
	logic [IW-1:0] rb_q;
	logic [CW-1:0] sza_q;
	logic [CW-1:0] score_q;
	logic [CW-1:0] best_q;
	logic [IW-1:0] seen_q [3];
	logic [2:0]    seen_cnt_q;

	logic [IW-1:0] cell_ra_q;
	logic          cell_rd_q;
	logic [IW-1:0] par_ra_q;
	logic [IW-1:0] par_rd_q;
	logic [IW-1:0] sz_ra_q;
	logic [CW-1:0] sz_rd_q;

	item_t         item;
	logic          cell_we;
	logic          par_we;
	logic [IW-1:0] par_wa;
	logic [IW-1:0] par_wd;
	logic          sz_we;
	logic [IW-1:0] sz_wa;
	logic [CW-1:0] sz_wd;
	logic          a_small;
	logic [CW-1:0] sz_sum;
	logic          nb_ok;
	logic [IW-1:0] nb_addr;
	logic          dup;
	logic          last_cell;
	logic [CW-1:0] total;
	logic [CW-1:0] result;
	logic [CW+OUT_W-1:0] result_wide;

	assign item = item_t'(q_data);

	// Write ports: initialize on load, link roots on a join.
	assign q_pop   = (state_q == S_IDLE) && !q_empty;
	assign cell_we = q_pop;
	assign a_small = (sza_q < sz_rd_q);
	assign sz_sum  = sza_q + sz_rd_q;
	assign par_we  = q_pop || (state_q == S_JOIN);
	assign sz_we   = par_we;
	assign par_wa  = q_pop ? item.idx : (a_small ? ra_q : rb_q);
	assign par_wd  = q_pop ? item.idx : (a_small ? rb_q : ra_q);
	assign sz_wa   = q_pop ? item.idx : (a_small ? rb_q : ra_q);
	assign sz_wd   = q_pop ? CW'(1) : sz_sum;

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[item.idx] <= item.land;
		end
		cell_rd_q <= cell_mem[cell_ra_q];
	end

	always_ff @(posedge clk) begin
		if (par_we) begin
			par_mem[par_wa] <= par_wd;
		end
		par_rd_q <= par_mem[par_ra_q];
	end

	always_ff @(posedge clk) begin
		if (sz_we) begin
			sz_mem[sz_wa] <= sz_wd;
		end
		sz_rd_q <= sz_mem[sz_ra_q];
	end

	// Neighbor of the current cell in direction k, and whether it lies inside the grid.
	always_comb begin
		case (k_q)
			DIR_UP: begin
				nb_ok   = (r_q != '0);
				nb_addr = i_q - IW'(n_q);
			end
			DIR_RIGHT: begin
				nb_ok   = (SW'(c_q) + SW'(1) < n_q);
				nb_addr = i_q + IW'(1);
			end
			DIR_DOWN: begin
				nb_ok   = (SW'(r_q) + SW'(1) < n_q);
				nb_addr = i_q + IW'(n_q);
			end
			DIR_LEFT: begin
				nb_ok   = (c_q != '0);
				nb_addr = i_q - IW'(1);
			end
			default: begin
				nb_ok   = 1'b0;
				nb_addr = i_q;
			end
		endcase
	end

	// A root already counted for this water cell.
	always_comb begin
		dup = 1'b0;
		for (int j = 0; j < 3; j++) begin
			if ((3'(j) < seen_cnt_q) && (seen_q[j] == x_q)) begin
				dup = 1'b1;
			end
		end
	end

	assign last_cell   = (SW'(r_q) + SW'(1) == n_q) && (SW'(c_q) + SW'(1) == n_q);
	assign total       = CW'(n_q * n_q);
	assign result      = all_land_q ? total : best_q;
	assign result_wide = {{OUT_W{1'b0}}, result};
	assign res_data    = result_wide[OUT_W-1:0];
	assign res_push    = (state_q == S_DONE) && !res_full;

	// Sequencer: one labeling pass, then one scoring pass over the grid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			scoring_q  <= 1'b0;
			find_sel_q <= 1'b0;
			all_land_q <= 1'b0;
			n_q        <= '0;
			i_q        <= '0;
			r_q        <= '0;
			c_q        <= '0;
			k_q        <= DIR_UP;
			x_q        <= '0;
			ra_q       <= '0;
			rb_q       <= '0;
			sza_q      <= '0;
			score_q    <= '0;
			best_q     <= '0;
			seen_cnt_q <= '0;
			cell_ra_q  <= '0;
			par_ra_q   <= '0;
			sz_ra_q    <= '0;
			for (int j = 0; j < 3; j++) begin
				seen_q[j] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_pop && item.last) begin
						n_q        <= item.side;
						all_land_q <= item.all_land;
						scoring_q  <= 1'b0;
						i_q        <= '0;
						r_q        <= '0;
						c_q        <= '0;
						state_q    <= S_CELL;
					end
				end
				S_CELL: begin
					cell_ra_q <= i_q;
					state_q   <= S_CELL_W;
				end
				S_CELL_W: begin
					state_q <= S_CELL_C;
				end
				S_CELL_C: begin
					if (scoring_q) begin
						score_q    <= CW'(1);
						seen_cnt_q <= '0;
						k_q        <= DIR_UP;
						state_q    <= cell_rd_q ? S_CELLEND : S_NB;
					end else begin
						k_q     <= DIR_LEFT;
						state_q <= cell_rd_q ? S_NB : S_NEXT;
					end
				end
				S_NB: begin
					if (nb_ok) begin
						cell_ra_q <= nb_addr;
						state_q   <= S_NB_W;
					end else begin
						state_q <= S_ADV;
					end
				end
				S_NB_W: begin
					state_q <= S_NB_C;
				end
				S_NB_C: begin
					if (cell_rd_q) begin
						x_q        <= nb_addr;
						find_sel_q <= 1'b0;
						state_q    <= S_FIND;
					end else begin
						state_q <= S_ADV;
					end
				end
				S_FIND: begin
					par_ra_q <= x_q;
					state_q  <= S_FIND_W;
				end
				S_FIND_W: begin
					state_q <= S_FIND_C;
				end
				S_FIND_C: begin
					if (par_rd_q != x_q) begin
						x_q     <= par_rd_q;
						state_q <= S_FIND;
					end else if (scoring_q) begin
						ra_q    <= x_q;
						state_q <= dup ? S_ADV : S_SZA;
					end else if (!find_sel_q) begin
						ra_q       <= x_q;
						x_q        <= i_q;
						find_sel_q <= 1'b1;
						state_q    <= S_FIND;
					end else begin
						rb_q    <= x_q;
						state_q <= (ra_q == x_q) ? S_ADV : S_SZA;
					end
				end
				S_SZA: begin
					sz_ra_q <= ra_q;
					state_q <= S_SZA_W;
				end
				S_SZA_W: begin
					state_q <= scoring_q ? S_ADD : S_SZB;
				end
				S_SZB: begin
					sza_q   <= sz_rd_q;
					sz_ra_q <= rb_q;
					state_q <= S_SZB_W;
				end
				S_SZB_W: begin
					state_q <= S_JOIN;
				end
				S_JOIN: begin
					state_q <= S_ADV;
				end
				S_ADD: begin
					score_q <= score_q + sz_rd_q;
					if (seen_cnt_q < 3'd3) begin
						seen_q[seen_cnt_q[1:0]] <= ra_q;
					end
					seen_cnt_q <= seen_cnt_q + 1'b1;
					state_q    <= S_ADV;
				end
				S_ADV: begin
					if (k_q == DIR_LEFT) begin
						if (scoring_q) begin
							state_q <= S_CELLEND;
						end else begin
							k_q     <= DIR_UP;
							state_q <= S_NB;
						end
					end else if (scoring_q) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_NB;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_CELLEND: begin
					if (score_q > best_q) begin
						best_q <= score_q;
					end
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (last_cell) begin
						i_q <= '0;
						r_q <= '0;
						c_q <= '0;
						if (scoring_q) begin
							state_q <= S_DONE;
						end else begin
							scoring_q <= 1'b1;
							best_q    <= '0;
							state_q   <= S_CELL;
						end
					end else begin
						i_q <= i_q + 1'b1;
						if (SW'(c_q) + SW'(1) == n_q) begin
							c_q <= '0;
							r_q <= r_q + 1'b1;
						end else begin
							c_q <= c_q + 1'b1;
						end
						state_q <= S_CELL;
					end
				end
				S_DONE: begin
					if (!res_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/largest_island_after_one_flip.sv
// Largest island after one flip. Cells of a square grid (side from the grid_side register,
// 1 to MAX_SIDE) are pushed in row-major order and stored at one cell per cycle while the
// sequencer is idle. After the last cell, the sequencer labels the land regions with
// union-find over a parent and a size memory, then scores every water cell by one plus the
// sizes of its distinct neighbor regions, and pops out the best score (side squared for an
// all-land grid). The work per cell is bounded by the one registered read port of each
// memory and by the serial walk to a region's root, which is at most twelve links deep
// under union by size. Cells of the next grid wait in a two-entry queue meanwhile, so full
// rises once two of them are waiting and stays high until the result has been handed over.
// Writing grid_side restarts the grid being loaded.
module largest_island_after_one_flip #(
	parameter int MAX_SIDE = lia_pkg::DEF_MAX_SIDE
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [lia_pkg::CFG_W-1:0] cfg_data,
	input  logic                      push,
	output logic                      full,
	input  logic                      cell_value,
	output logic                      empty,
	input  logic                      pop,
	output logic [lia_pkg::OUT_W-1:0] largest_size
);
	import lia_pkg::*;

	localparam int MAX_CELLS = MAX_SIDE * MAX_SIDE;
	localparam int IW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int ITEM_W = IW + SW + 3;

	logic              q_push;
	logic              q_full;
	logic [ITEM_W-1:0] q_wdata;
	logic [ITEM_W-1:0] q_rdata;
	logic              q_empty;
	logic              q_pop;
	logic              res_push;
	logic              res_full;
	logic [OUT_W-1:0]  res_data;

	// Front: register port and cell intake.
	lia_loader #(.MAX_SIDE(MAX_SIDE), .ITEM_W(ITEM_W)) u_loader (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.push(push), .full(full), .cell_value(cell_value),
		.q_push(q_push), .q_full(q_full), .q_data(q_wdata)
	);

	// Queue between front and back.
	lia_queue #(.W(ITEM_W), .DEPTH(2)) u_cell_q (
		.clk(clk), .arst_n(arst_n),
		.wr_en(q_push), .wr_data(q_wdata), .full(q_full),
		.rd_en(q_pop), .rd_data(q_rdata), .empty(q_empty)
	);

	// Back: storage, labeling and scoring.
	lia_labeler #(.MAX_SIDE(MAX_SIDE), .ITEM_W(ITEM_W)) u_labeler (
		.clk(clk), .arst_n(arst_n),
		.q_data(q_rdata), .q_empty(q_empty), .q_pop(q_pop),
		.res_push(res_push), .res_full(res_full), .res_data(res_data)
	);

	// Result queue seen by the consumer.
	lia_queue #(.W(OUT_W), .DEPTH(2)) u_res_q (
		.clk(clk), .arst_n(arst_n),
		.wr_en(res_push), .wr_data(res_data), .full(res_full),
		.rd_en(pop), .rd_data(largest_size), .empty(empty)
	);

endmodule

// File: hw/rtl/lia_checker.sv
// Port-level checks for the largest-island block, bound to its top level.
// Depends on lia_pkg and the top-level port list.
module lia_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      empty,
	input logic                      pop,
	input logic                      push,
	input logic                      full,
	input logic [lia_pkg::OUT_W-1:0] largest_size
);
	import lia_pkg::*;

	// No result is waiting once reset has been seen at a clock edge.
	a_empty_in_reset: assert property (@(posedge clk) !arst_n |=> empty)
		else $error("result waiting during reset");

	// A waiting result stays until it is popped.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(largest_size)))
		else $error("waiting result changed before pop");

	// Every island score is at least one.
	a_result_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (largest_size != '0))
		else $error("result of zero");

	// A waiting result and the input stall flag always carry known values.
	a_result_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(full) && (empty || !$isunknown(largest_size)))
		else $error("unknown value on full or on a waiting result");

endmodule

bind largest_island_after_one_flip lia_checker u_lia_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.push(push), .full(full), .largest_size(largest_size)
);

// File: tb/testbench.sv
// Testbench for the largest-island-after-one-flip block: loads square grids cell by cell,
// predicts each grid's best score with its own flood-fill model and checks every result.
// Depends on lia_pkg and largest_island_after_one_flip.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lia_pkg::*;

	localparam int MAXS     = DEF_MAX_SIDE;
	localparam int CELLS    = MAXS * MAXS;
	localparam int SETTLE   = 64;
	localparam int LONG_HOLD = 400;

	// Kinds of rows in the directed table.
	typedef enum logic [1:0] {ROW_SIDE, ROW_CELL, ROW_CELL_LIT} row_kind_t;
	typedef struct packed {
		row_kind_t        kind;
		logic [CFG_W-1:0] data;
		logic [OUT_W-1:0] lit;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 push = 1'b0;
	logic                 full;
	logic                 cell_value = 1'b0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [OUT_W-1:0]     largest_size;

	// Predictor state: side in use, loaded cells and the position within the grid.
	int                   side_now = MAXS;
	bit                   grid_bits [CELLS];
	int                   fill_pos = 0;
	int                   land_count = 0;
	logic [OUT_W-1:0]     score_q [$];

	int                   errors = 0;
	int                   grids_done = 0;
	int                   cells_sent = 0;
	int                   checked = 0;
	bit                   gaps_on = 1'b0;
	int                   hold_left = 0;

	largest_island_after_one_flip uut (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .push(push), .full(full), .cell_value(cell_value),
		.empty(empty), .pop(pop), .largest_size(largest_size)
	);

	always #6 clk = ~clk;

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Best score of the loaded grid: label land regions by flood fill, then score water cells.
	function automatic logic [OUT_W-1:0] island_score(input int n);
		int lbl [CELLS];
		int sz [CELLS + 1];
		int stk [CELLS];
		int drow [4];
		int dcol [4];
		int seen [4];
		int nl, sp, cur, r, c, k, nr, nc, best, s, nseen, j;
		bit dup;
		drow = '{-1, 0, 1, 0};
		dcol = '{0, 1, 0, -1};
		nl = 0;
		best = 0;
		for (int i = 0; i < n * n; i++) lbl[i] = 0;
		for (int i = 0; i < n * n; i++) begin
			if (grid_bits[i] && lbl[i] == 0) begin
				nl++;
				sz[nl] = 0;
				lbl[i] = nl;
				stk[0] = i;
				sp = 1;
				while (sp > 0) begin
					sp--;
					cur = stk[sp];
					sz[nl]++;
					for (k = 0; k < 4; k++) begin
						nr = cur / n + drow[k];
						nc = cur % n + dcol[k];
						if (nr >= 0 && nr < n && nc >= 0 && nc < n &&
								grid_bits[nr * n + nc] && lbl[nr * n + nc] == 0) begin
							lbl[nr * n + nc] = nl;
							stk[sp] = nr * n + nc;
							sp++;
						end
					end
				end
			end
		end
		for (r = 0; r < n; r++) begin
			for (c = 0; c < n; c++) begin
				s = 1;
				if (!grid_bits[r * n + c]) begin
					nseen = 0;
					for (k = 0; k < 4; k++) begin
						nr = r + drow[k];
						nc = c + dcol[k];
						if (nr >= 0 && nr < n && nc >= 0 && nc < n && grid_bits[nr * n + nc]) begin
							dup = 1'b0;
							for (j = 0; j < nseen; j++)
								if (seen[j] == lbl[nr * n + nc]) dup = 1'b1;
							if (!dup) begin
								seen[nseen] = lbl[nr * n + nc];
								nseen++;
								s += sz[lbl[nr * n + nc]];
							end
						end
					end
				end
				if (s > best) best = s;
			end
		end
		if (land_count == n * n) best = n * n;
		return best[OUT_W-1:0];
	endfunction

	// Accepts one cell into the predictor; returns 1 when the grid is complete.
	function automatic bit load_cell(input bit v);
		grid_bits[fill_pos] = v;
		land_count += v;
		fill_pos++;
		return fill_pos == side_now * side_now;
	endfunction

	// Writes grid_side once the block is idle; a partial grid is discarded.
	task automatic write_side(input logic [CFG_W-1:0] v);
		wait (score_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		side_now = (v == 0) ? 1 : (v > MAXS) ? MAXS : int'(v);
		fill_pos = 0;
		land_count = 0;
	endtask

	// Pushes one cell; lit of zero means the expected score comes from the predictor.
	task automatic send_cell(input bit v, input logic [OUT_W-1:0] lit);
		int gap;
		logic [OUT_W-1:0] sc;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		cell_value <= v;
		@(posedge clk);
		while (full) @(posedge clk);
		cells_sent++;
		if (load_cell(v)) begin
			sc = island_score(side_now);
			score_q.push_back(lit != 0 ? lit : sc);
			fill_pos = 0;
			land_count = 0;
			grids_done++;
		end
	endtask

	task automatic stop_push();
		push <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: check each transaction, then pick the next pop level.
	initial begin : result_side
		int gap;
		gap = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				checked++;
				if (score_q.size() == 0)
					report($sformatf("unexpected result %0d", largest_size));
				else if (score_q[0] !== largest_size) begin
					report($sformatf("largest_size %0d, expected %0d", largest_size, score_q[0]));
					void'(score_q.pop_front());
				end else
					void'(score_q.pop_front());
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				pop <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(0, 3);
				pop <= 1'b0;
			end else
				pop <= 1'b1;
		end
	end

	initial begin : watchdog
		#40_000_000;
		$display("timeout waiting for results");
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		row_t rows [25];
		int n, dens, part;
		rows = '{
			'{ROW_SIDE, 7'd0, 13'd0}, '{ROW_CELL_LIT, 7'd1, 13'd1}, '{ROW_CELL_LIT, 7'd0, 13'd1},
			'{ROW_SIDE, 7'd1, 13'd0}, '{ROW_CELL_LIT, 7'd0, 13'd1},
			// Two by two: all land, all water, then a diagonal pair joined by one flip.
			'{ROW_SIDE, 7'd2, 13'd0}, '{ROW_CELL, 7'd1, 13'd0}, '{ROW_CELL, 7'd1, 13'd0},
			'{ROW_CELL, 7'd1, 13'd0}, '{ROW_CELL_LIT, 7'd1, 13'd4},
			'{ROW_CELL, 7'd0, 13'd0}, '{ROW_CELL, 7'd0, 13'd0}, '{ROW_CELL, 7'd0, 13'd0},
			'{ROW_CELL_LIT, 7'd0, 13'd1},
			'{ROW_CELL, 7'd1, 13'd0}, '{ROW_CELL, 7'd0, 13'd0}, '{ROW_CELL, 7'd0, 13'd0},
			'{ROW_CELL_LIT, 7'd1, 13'd3},
			// Three by three checkerboard corners.
			'{ROW_SIDE, 7'd3, 13'd0}, '{ROW_CELL, 7'd1, 13'd0}, '{ROW_CELL, 7'd0, 13'd0},
			'{ROW_CELL, 7'd1, 13'd0}, '{ROW_CELL, 7'd0, 13'd0}, '{ROW_CELL, 7'd0, 13'd0},
			'{ROW_CELL, 7'd0, 13'd0}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Partial grid at the reset side, discarded by the first register write.
		for (int i = 0; i < 5; i++) send_cell(i[0], '0);
		stop_push();

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_SIDE) begin
				stop_push();
				write_side(rows[i].data);
			end else
				send_cell(rows[i].data[0], rows[i].kind == ROW_CELL_LIT ? rows[i].lit : '0);
		end
		send_cell(1'b1, '0);
		send_cell(1'b0, '0);
		send_cell(1'b1, '0);
		stop_push();

		// Side above the limit is clamped: a partial grid at that side gives no result and
		// is dropped by the next write.
		write_side(7'd127);
		for (int i = 0; i < 40; i++) send_cell(1'b1, '0);
		stop_push();

		// Output backpressure: one-cell grids while results are held back.
		write_side(7'd1);
		hold_left = LONG_HOLD;
		for (int i = 0; i < 30; i++) send_cell(1'($urandom_range(0, 1)), '0);
		stop_push();

		// Random grids, mostly small, with random land density.
		gaps_on = 1'b1;
		while (cells_sent < 1100) begin
			if (cells_sent > 900) gaps_on = 1'b0;
			case ($urandom_range(0, 15))
				0: n = 0;
				1: n = 16;
				default: n = $urandom_range(1, 8);
			endcase
			stop_push();
			write_side(CFG_W'(n));
			n = (n == 0) ? 1 : n;
			dens = $urandom_range(0, 100);
			// Now and then a grid is cut short by the next write.
			part = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n * n) - 1 : n * n;
			if (part == 0 && n * n > 1) part = 1;
			for (int i = 0; i < part; i++)
				send_cell($urandom_range(0, 99) < dens, '0);
		end
		stop_push();

		wait (score_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
		$display("%0d cells over %0d complete grids of side 1 to 16, %0d results checked,",
			cells_sent, grids_done, checked);
		$display("with side clamping, discarded partial grids and long input and output stalls");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
